>>> rtl/bhpq_pkg.sv
// shared constants and codes for the binary min-heap priority queue
package bhpq_pkg;

   localparam int DEF_CAPACITY  = 1024;
   localparam int DEF_KEY_WIDTH = 32;

   localparam int IN_KEY_WIDTH    = 32;
   localparam int OUT_KEY_WIDTH   = 32;
   localparam int OUT_COUNT_WIDTH = 11;
   localparam int STATUS_WIDTH    = 2;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

endpackage

>>> rtl/binary_min_heap_priority_queue.sv
// binary min-heap priority queue over signed keys, with one memory port pair
//
// usage: present req_func (push or pop) and req_key_value with start high while busy is
// low; that cycle is the input transfer. busy stays high while the heap is repaired.
// each operation gives exactly one result on the rsp_ ports, marked by rsp_strobe for a
// single cycle; the receiver cannot hold it off and it is taken at the end of that cycle.
// rsp_entry_count is the number of keys held after the operation (modulo 2048).
// a push to a full heap or a pop on an empty heap is answered in the cycle after the
// transfer with the matching status and no change to the heap.
// sequencing: the heap memory has one registered read port, and the sequencer walks one
// level per step. a push reads the parent and compares for each level it climbs, then
// writes the key; a pop reads the root, reads the last entry, loads it, then for each
// level reads the left and right children and compares, and finally writes the key.
// the result is strobed in the first cycle with busy low, and a new transfer is possible
// in the cycle the result is strobed.
// reset (synchronous, active high) empties the heap at once; the heap memory itself is
// not cleared, since only entries below the fill count are ever used.
module binary_min_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic signed [IN_KEY_WIDTH-1:0]    req_key_value,
   output logic                              rsp_strobe,
   output logic        [STATUS_WIDTH-1:0]    rsp_status,
   output logic signed [OUT_KEY_WIDTH-1:0]   rsp_popped_key,
   output logic        [OUT_COUNT_WIDTH-1:0] rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH_RD,
      S_PUSH_CMP,
      S_POP_ROOT,
      S_POP_LAST,
      S_POP_LOAD,
      S_DN_RD_L,
      S_DN_RD_R,
      S_DN_CMP,
      S_WRITE_KEY
   } state_type;

   logic signed [KEY_WIDTH-1:0] heap_mem [CAPACITY];
   logic signed [KEY_WIDTH-1:0] rd_data_ff;

   state_type                   state_ff, state_in;
   logic        [CW-1:0]        count_ff, count_in;
   logic        [AW-1:0]        pos_ff, pos_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic signed [KEY_WIDTH-1:0] left_ff, left_in;
   logic                        strobe_ff, strobe_in;
   status_type                  status_ff, status_in;
   logic signed [KEY_WIDTH-1:0] popped_ff, popped_in;

   logic                        mem_we;
   logic        [AW-1:0]        mem_waddr;
   logic        [AW-1:0]        mem_raddr;
   logic signed [KEY_WIDTH-1:0] mem_wdata;

   logic                        accept;
   logic        [CW-1:0]        count_dec;
   logic        [AW-1:0]        parent_pos;
   logic        [XW-1:0]        left_idx;
   logic        [XW-1:0]        right_idx;
   logic        [XW-1:0]        count_x;
   logic                        left_ok;
   logic                        right_ok;
   logic                        take_right;
   logic signed [KEY_WIDTH-1:0] child_key;
   logic        [AW-1:0]        child_pos;

   assign accept     = start && (state_ff == S_IDLE);
   assign count_dec  = count_ff - CW'(1);
   assign parent_pos = AW'((pos_ff - AW'(1)) >> 1);
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = {1'b0, pos_ff, 1'b0} + XW'(2);
   assign count_x    = XW'(count_ff);
   assign left_ok    = left_idx < count_x;
   assign right_ok   = right_idx < count_x;
   // the right child wins only when strictly smaller than the left one
   assign take_right = right_ok && (rd_data_ff < left_ff);
   assign child_key  = take_right ? rd_data_ff : left_ff;
   assign child_pos  = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      popped_in = popped_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff;
      mem_wdata = key_ff;
      mem_raddr = parent_pos;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_OK;
               popped_in = '0;
               if (req_func == FUNC_PUSH) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                     strobe_in = 1'b1;
                  end else begin
                     key_in   = KEY_WIDTH'(req_key_value);
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     state_in = (count_ff == '0) ? S_WRITE_KEY : S_PUSH_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     strobe_in = 1'b1;
                  end else begin
                     count_in = count_dec;
                     state_in = S_POP_ROOT;
                  end
               end
            end
         end
         S_PUSH_RD: begin
            mem_raddr = parent_pos;
            state_in  = S_PUSH_CMP;
         end
         S_PUSH_CMP: begin
            if (key_ff < rd_data_ff) begin
               // parent moves down into the hole
               mem_we    = 1'b1;
               mem_wdata = rd_data_ff;
               pos_in    = parent_pos;
               state_in  = (parent_pos == '0) ? S_WRITE_KEY : S_PUSH_RD;
            end else begin
               mem_we    = 1'b1;
               state_in  = S_IDLE;
               strobe_in = 1'b1;
            end
         end
         S_POP_ROOT: begin
            mem_raddr = '0;
            state_in  = S_POP_LAST;
         end
         S_POP_LAST: begin
            popped_in = rd_data_ff;
            mem_raddr = count_ff[AW-1:0];
            state_in  = S_POP_LOAD;
         end
         S_POP_LOAD: begin
            key_in   = rd_data_ff;
            pos_in   = '0;
            state_in = S_DN_RD_L;
         end
         S_DN_RD_L: begin
            mem_raddr = left_idx[AW-1:0];
            state_in  = left_ok ? S_DN_RD_R : S_WRITE_KEY;
         end
         S_DN_RD_R: begin
            left_in   = rd_data_ff;
            mem_raddr = right_idx[AW-1:0];
            state_in  = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (child_key < key_ff) begin
               mem_we    = 1'b1;
               mem_wdata = child_key;
               pos_in    = child_pos;
               state_in  = S_DN_RD_L;
            end else begin
               state_in = S_WRITE_KEY;
            end
         end
         S_WRITE_KEY: begin
            mem_we    = 1'b1;
            state_in  = S_IDLE;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      left_ff   <= left_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= heap_mem[mem_raddr];
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_popped_key  = OUT_KEY_WIDTH'(popped_ff);
   assign rsp_entry_count = OUT_COUNT_WIDTH'(count_ff);

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while still busy");

   a_transfer_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("transfer neither answered nor in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_FULL)) |-> (count_ff == CW'(CAPACITY)))
      else $error("full status with room left");

endmodule
